// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl of the frame-rate meter
// no dependencies; assertions compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, switched off while reset is low
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// clocked check that also holds during reset
`define ASSERT_CLKD_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLKD_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/core/maf_pkg.sv -----
// shared widths, codes and constants of the frame-rate meter
// no dependencies; used by the stream interfaces and the top level
package maf_pkg;

    localparam int TIME_W         = 32;
    localparam int WIN_W          = 7;
    localparam int FPS_W          = 23;
    localparam int MAX_WINDOW_DEF = 64;
    localparam int WINDOW_RST     = 10;
    localparam int MS_CENTI       = 100000;
    localparam longint FPS_MAX    = (longint'(1) << FPS_W) - 1;

    // kind codes of an input transaction
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

endpackage

// ----- rtl/core/maf_stream_if.sv -----
// valid/ready stream interfaces of the frame-rate meter
// depends on maf_pkg for the field widths
interface maf_in_if import maf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, kind, now_ms, input ready);
    modport sink   (input valid, kind, now_ms, output ready);
endinterface

interface maf_out_if import maf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [FPS_W-1:0] fps_centi;
    logic [WIN_W-1:0] frames_in_window;
    logic             zero_time;

    modport source (output valid, fps_centi, frames_in_window, zero_time, input ready);
    modport sink   (input valid, fps_centi, frames_in_window, zero_time, output ready);
endinterface

// ----- rtl/core/moving_average_frame_rate.sv -----
// top level of the moving-average frame-rate meter: ring memory, running sum, divider
// depends on maf_pkg, maf_stream_if and assert_macros.svh
//
//  channel   dir  handshake           payload
//  i_frame   in   valid/ready         kind, now_ms
//  o_rate    out  valid/ready         fps_centi, frames_in_window, zero_time
//  i_cfg     in   i_cfg_we only       i_cfg_wdata (window length)
//
// a start transaction goes from acceptance straight to the done state and the result register
// a frame transaction runs in order: ring read at acceptance, subtract of the retired
// interval plus ring write, add, then one quotient bit per cycle from a restoring divider
// one transaction at a time; i_frame.ready is high only when the sequencer is idle, so
// the next transaction is taken in the cycle after the result register loads at the earliest,
// and a new transaction is taken while the last result still waits on o_rate
// a finished result holds the sequencer while o_rate still has an unaccepted result
// synchronous active-low reset clears the history; the ring is never cleared, entries
// are only read after being written since the last clear
`include "assert_macros.svh"

module moving_average_frame_rate import maf_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    maf_in_if.sink           i_frame,
    maf_out_if.source        o_rate,
    input  logic             i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_wdata
);

    // largest window the 7-bit register can select at this ring size
    localparam int WIN_CAP = (MAX_WINDOW > (1 << WIN_W) - 1) ? (1 << WIN_W) - 1 : MAX_WINDOW;
    localparam int IDX_W   = $clog2(MAX_WINDOW);
    localparam int CMP_W   = ((IDX_W > WIN_W) ? IDX_W : WIN_W) + 1;
    localparam int SUM_W   = TIME_W + $clog2(WIN_CAP + 1);
    localparam int NUM_W   = $clog2(MS_CENTI * WIN_CAP + 1);
    localparam int CNT_W   = $clog2(NUM_W);
    localparam longint SAT_FULL = longint'(MS_CENTI) * longint'(MAX_WINDOW);
    localparam logic [FPS_W-1:0] SAT =
        (SAT_FULL > FPS_MAX) ? FPS_W'(FPS_MAX) : FPS_W'(SAT_FULL);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUB  = 5'b00010,
        S_ADD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [WIN_W-1:0]   r_window;
    logic [TIME_W-1:0]  r_last_time;
    logic [IDX_W-1:0]   r_write_slot;
    logic [WIN_W-1:0]   r_filled;
    logic [SUM_W-1:0]   r_sum;
    logic               r_is_start;
    logic [CNT_W-1:0]   r_div_cnt;

    // datapath registers, no reset
    logic [TIME_W-1:0]  r_interval;
    logic [IDX_W-1:0]   r_slot;
    logic [TIME_W-1:0]  r_rd_data;
    logic [SUM_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_quo;

    // output register
    logic               r_out_valid;
    logic [FPS_W-1:0]   r_out_fps;
    logic [WIN_W-1:0]   r_out_frames;
    logic               r_out_zero;

    // interval ring
    logic [TIME_W-1:0]  r_ring [MAX_WINDOW];

    logic [WIN_W-1:0]   w_eff;
    logic [CMP_W-1:0]   w_ext;
    logic [IDX_W-1:0]   cur_slot;
    logic [CMP_W-1:0]   slot_inc;
    logic [IDX_W-1:0]   next_slot;
    logic               in_acc;
    logic               out_free;
    logic [SUM_W:0]     div_shift;
    logic [SUM_W:0]     div_diff;
    logic               fps_clamp;
    logic [FPS_W-1:0]   fps_res;

    // effective window: zero acts as one, clamped to the ring size
    assign w_eff = (r_window == '0) ? WIN_W'(1)
                 : ((r_window > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : r_window);
    assign w_ext = CMP_W'(w_eff);

    // slot for the coming frame, wrapped if the window shrank
    assign cur_slot  = (CMP_W'(r_write_slot) >= w_ext) ? '0 : r_write_slot;
    assign slot_inc  = CMP_W'(r_slot) + CMP_W'(1);
    assign next_slot = (slot_inc >= w_ext) ? '0 : slot_inc[IDX_W-1:0];

    assign in_acc   = i_frame.valid && i_frame.ready;
    assign out_free = !r_out_valid || o_rate.ready;

    // one restoring step per cycle, numerator bits shift out of r_quo
    assign div_shift = {r_rem, r_quo[NUM_W-1]};
    assign div_diff  = div_shift - {1'b0, r_sum};

    assign fps_clamp = 32'(r_quo) > 32'(SAT);
    always_comb begin
        if (r_is_start) begin
            fps_res = '0;
        end else if (r_sum == '0) begin
            fps_res = SAT;
        end else if (fps_clamp) begin
            fps_res = SAT;
        end else begin
            fps_res = FPS_W'(r_quo);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_frame.kind == KIND_START) ? S_DONE : S_SUB;
                end
            end
            S_SUB:  n_state = S_ADD;
            S_ADD:  n_state = S_DIV;
            S_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and history state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window     <= WIN_W'(WINDOW_RST);
            r_last_time  <= '0;
            r_write_slot <= '0;
            r_filled     <= '0;
            r_sum        <= '0;
            r_is_start   <= 1'b0;
            r_div_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // result register loads when free, else empties on acceptance
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rate.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_last_time <= i_frame.now_ms;
                        r_is_start  <= (i_frame.kind == KIND_START);
                        if (i_frame.kind == KIND_START) begin
                            r_write_slot <= '0;
                            r_filled     <= '0;
                            r_sum        <= '0;
                        end
                    end
                end
                S_SUB: begin
                    // retire the overwritten interval once the window is full
                    if (r_filled >= w_eff) begin
                        r_sum    <= r_sum - SUM_W'(r_rd_data);
                        r_filled <= w_eff;
                    end else begin
                        r_filled <= r_filled + WIN_W'(1);
                    end
                    r_write_slot <= next_slot;
                end
                S_ADD: begin
                    r_sum     <= r_sum + SUM_W'(r_interval);
                    r_div_cnt <= CNT_W'(NUM_W - 1);
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt - CNT_W'(1);
                end
                S_DONE: ;
                default: ;
            endcase
            // window write restarts the history, last time kept; the user writes only while idle, not enforced here
            if (i_cfg_we) begin
                r_window     <= i_cfg_wdata;
                r_write_slot <= '0;
                r_filled     <= '0;
                r_sum        <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_interval <= i_frame.now_ms - r_last_time;
            r_slot     <= cur_slot;
        end
        if (r_state == S_ADD) begin
            r_quo <= NUM_W'(MS_CENTI * int'(r_filled));
            r_rem <= '0;
        end
        if (r_state == S_DIV) begin
            if (!div_diff[SUM_W]) begin
                r_rem <= div_diff[SUM_W-1:0];
            end else begin
                r_rem <= div_shift[SUM_W-1:0];
            end
            r_quo <= {r_quo[NUM_W-2:0], !div_diff[SUM_W]};
        end
        if (r_state == S_DONE && out_free) begin
            r_out_fps    <= fps_res;
            r_out_frames <= r_filled;
            r_out_zero   <= !r_is_start && (r_sum == '0);
        end
    end

    // ring: read at acceptance, write back during the subtract cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_rd_data <= r_ring[cur_slot];
        end
        if (r_state == S_SUB) begin
            r_ring[r_slot] <= r_interval;
        end
    end

    assign i_frame.ready           = (r_state == S_IDLE);
    assign o_rate.valid            = r_out_valid;
    assign o_rate.fps_centi        = r_out_fps;
    assign o_rate.frames_in_window = r_out_frames;
    assign o_rate.zero_time        = r_out_zero;

    `ASSERT_CLKD(a_acc_leaves_idle, i_clk, i_rst_n, in_acc |=> r_state != S_IDLE, "accepted transaction left sequencer idle")
    `ASSERT_CLKD(a_filled_in_window, i_clk, i_rst_n, r_filled <= w_eff, "interval count exceeds window")
    `ASSERT_CLKD(a_slot_in_window, i_clk, i_rst_n, CMP_W'(r_write_slot) < w_ext || r_state == S_IDLE, "write slot outside window")
    `ASSERT_CLKD(a_zero_saturates, i_clk, i_rst_n, r_out_valid && r_out_zero |-> r_out_fps == SAT, "zero interval sum without saturated rate")
    `ASSERT_CLKD(a_div_ends, i_clk, i_rst_n, r_state == S_DIV && r_div_cnt == '0 |=> r_state == S_DONE, "divider did not finish on count")

endmodule
